// ----- sv/lnss_pkg.sv -----
// Package for the link notify sensor sequencer: phase and event codes,
// register indexes, slot sizing and field widths.
// No dependencies.
`default_nettype none

package lnss_pkg;

    // Number of sensor slots served round-robin.
    localparam int SENSOR_SLOTS = 8;
    localparam int SLOT_W       = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

    localparam int EVENT_W  = 2;
    localparam int MS_W     = 16;
    localparam int SENSOR_W = 3;
    localparam int CFG_W    = 16;
    localparam int INDEX_W  = 1;

    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

    // The slot after the last one: slot 1, or slot 0 when there is only one slot.
    localparam logic [SLOT_W-1:0] WRAP_SLOT  = SLOT_W'((SENSOR_SLOTS == 1) ? 0 : 1);
    localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SENSOR_SLOTS);

    localparam logic [MS_W-1:0] DELAY_LIMIT_RESET = MS_W'(1000);
    localparam logic [MS_W-1:0] ACK_TIMEOUT_RESET = MS_W'(500);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_REFRESH  = 2'd1,
        PH_WAIT_ACK = 2'd2,
        PH_DELAY    = 2'd3
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE         = 2'd0,
        EV_CONNECTED    = 2'd1,
        EV_DISCONNECTED = 2'd2,
        EV_ACK          = 2'd3
    } event_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_DELAY_LIMIT = 1'd0,
        REG_ACK_TIMEOUT = 1'd1
    } reg_index_t;

endpackage

`default_nettype wire

// ----- sv/link_notify_sensor_sequencer_core.sv -----
// Link notify sensor sequencer: phase sequencer, saturating millisecond
// counter and round-robin sensor slot selection with one result per event.
// Depends on lnss_pkg.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_tvalid / s_tready        s_tdata: event_code, elapsed_ms
// m_axis    out        m_tvalid / m_tready        m_tdata: new_sensor
// config    in         wr_en (no wait)            wr_index, wr_data
//
// Each event's state update and result are computed from the accepted
// transfer and the state registers, and the result lands in the output
// register. One event per cycle is sustained while the sink takes each result.
// s_tready is low only while a result waits in the output register and the
// sink does not take it. Reset clears the phase, counter, slots and output valid flag.

module link_notify_sensor_sequencer_core
    import lnss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [1:0] event_code, [17:2] elapsed_ms, [23:18] zero
    input  wire logic [23:0]         s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [2:0] new_sensor, [7:3] zero
    output logic [7:0]               m_tdata,
    input  wire logic                wr_en,
    input  wire logic [INDEX_W-1:0]  wr_index,
    input  wire logic [CFG_W-1:0]    wr_data
);

    phase_t              phase_reg, phase_next;
    logic [MS_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]   chosen_slot_reg, chosen_slot_next;
    logic [SLOT_W-1:0]   reported_slot_reg, reported_slot_next;
    logic [MS_W-1:0]     delay_limit_reg;
    logic [MS_W-1:0]     ack_timeout_reg;
    logic                out_valid_reg;
    logic [SENSOR_W-1:0] sensor_reg, sensor_next;

    event_t              event_in;
    logic [MS_W-1:0]     elapsed_in;
    logic                accept;
    logic [MS_W:0]       count_sum;
    logic [MS_W-1:0]     count_sat;
    logic [SLOT_W:0]     slot_inc;
    logic [SLOT_W-1:0]   slot_adv;
    logic [SLOT_W+SENSOR_W-1:0] slot_ext;

    assign event_in   = event_t'(s_tdata[EVENT_W-1:0]);
    assign elapsed_in = s_tdata[EVENT_W+MS_W-1:EVENT_W];
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    assign count_sum = {1'b0, count_reg} + {1'b0, elapsed_in};
    assign count_sat = count_sum[MS_W] ? MS_MAX : count_sum[MS_W-1:0];

    assign slot_inc = {1'b0, chosen_slot_reg} + (SLOT_W + 1)'(1);
    assign slot_adv = (slot_inc >= SLOT_LIMIT) ? WRAP_SLOT : slot_inc[SLOT_W-1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_sat;
        chosen_slot_next = chosen_slot_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (event_in == EV_CONNECTED)
                    phase_next = PH_REFRESH;
            end
            PH_REFRESH:
            begin
                if (event_in == EV_DISCONNECTED)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    chosen_slot_next = slot_adv;
                    phase_next       = PH_WAIT_ACK;
                    count_next       = '0;
                end
            end
            PH_WAIT_ACK:
            begin
                if (event_in == EV_ACK)
                    phase_next = PH_DELAY;
                else if (event_in == EV_DISCONNECTED)
                    phase_next = PH_IDLE;
                else if (count_sat >= ack_timeout_reg)
                    phase_next = PH_DELAY;
            end
            PH_DELAY:
            begin
                if (event_in == EV_DISCONNECTED)
                    phase_next = PH_IDLE;
                else if (count_sat >= delay_limit_reg)
                    phase_next = PH_REFRESH;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Report the slot only when it differs from the one last reported.
    assign slot_ext = {{SENSOR_W{1'b0}}, chosen_slot_next};

    always_comb
    begin
        reported_slot_next = reported_slot_reg;
        sensor_next        = '0;
        if (reported_slot_reg != chosen_slot_next)
        begin
            reported_slot_next = chosen_slot_next;
            sensor_next        = slot_ext[SENSOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            count_reg         <= '0;
            chosen_slot_reg   <= '0;
            reported_slot_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            count_reg         <= count_next;
            chosen_slot_reg   <= chosen_slot_next;
            reported_slot_reg <= reported_slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_limit_reg <= DELAY_LIMIT_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_DELAY_LIMIT: delay_limit_reg <= wr_data[MS_W-1:0];
                REG_ACK_TIMEOUT: ack_timeout_reg <= wr_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sensor_reg <= sensor_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - SENSOR_W){1'b0}}, sensor_reg};

    // After every event the reported slot has caught up with the chosen slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        reported_slot_reg == chosen_slot_reg)
        else $error("reported slot lags chosen slot");

    // The chosen slot never leaves the slot range.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, chosen_slot_reg} < SLOT_LIMIT)
        else $error("chosen slot out of range");

    // A refresh that is not cancelled clears the counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_REFRESH && event_in != EV_DISCONNECTED)
        |=> (count_reg == '0 && phase_reg == PH_WAIT_ACK))
        else $error("refresh did not clear counter");

    // Every accepted event leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted event produced no result");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for link_notify_sensor_sequencer_core: streams link events,
// predicts the reported sensor slot of each transfer and checks every result.
// Depends on lnss_pkg and the core module.
`timescale 1ns / 100ps

module tb_top
    import lnss_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [5:0]      pad;
        logic [MS_W-1:0] elapsed_ms;
        event_t          event_code;
    } link_item_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;
    logic                wr_en    = 1'b0;
    logic [INDEX_W-1:0]  wr_index = '0;
    logic [CFG_W-1:0]    wr_data  = '0;

    // Predicted sequencer state and register copies.
    phase_t              seq_phase     = PH_IDLE;
    logic [MS_W-1:0]     ms_count      = '0;
    logic [SLOT_W-1:0]   chosen_slot   = '0;
    logic [SLOT_W-1:0]   reported_slot = '0;
    logic [CFG_W-1:0]    delay_limit   = DELAY_LIMIT_RESET;
    logic [CFG_W-1:0]    ack_timeout   = ACK_TIMEOUT_RESET;

    link_item_t          pending_events[$];
    logic [SENSOR_W-1:0] expected_sensors[$];

    int  cycle_count   = 0;
    int  mismatches    = 0;
    bit  calm          = 1'b0;
    bit  offer_taken   = 1'b0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;

    link_notify_sensor_sequencer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        if (mismatches < 50)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Advances the predicted sequencer by one event and returns the slot it reports.
    function automatic logic [SENSOR_W-1:0] predict_new_sensor(link_item_t it);
        logic [MS_W:0]       sum;
        logic [SLOT_W:0]     bumped;
        logic [SENSOR_W-1:0] sensor;
        sum      = {1'b0, ms_count} + {1'b0, it.elapsed_ms};
        ms_count = sum[MS_W] ? MS_MAX : sum[MS_W-1:0];
        sensor   = '0;
        case (seq_phase)
            PH_IDLE:
            begin
                if (it.event_code == EV_CONNECTED)
                    seq_phase = PH_REFRESH;
            end
            PH_REFRESH:
            begin
                if (it.event_code == EV_DISCONNECTED)
                    seq_phase = PH_IDLE;
                else
                begin
                    bumped      = {1'b0, chosen_slot} + (SLOT_W + 1)'(1);
                    chosen_slot = (bumped >= SLOT_LIMIT) ? WRAP_SLOT : bumped[SLOT_W-1:0];
                    seq_phase   = PH_WAIT_ACK;
                    ms_count    = '0;
                end
            end
            PH_WAIT_ACK:
            begin
                if (it.event_code == EV_ACK)
                    seq_phase = PH_DELAY;
                else if (it.event_code == EV_DISCONNECTED)
                    seq_phase = PH_IDLE;
                else if (ms_count >= ack_timeout)
                    seq_phase = PH_DELAY;
            end
            default:
            begin
                if (it.event_code == EV_DISCONNECTED)
                    seq_phase = PH_IDLE;
                else if (ms_count >= delay_limit)
                    seq_phase = PH_REFRESH;
            end
        endcase
        if (reported_slot != chosen_slot)
        begin
            sensor        = SENSOR_W'(chosen_slot);
            reported_slot = chosen_slot;
        end
        return sensor;
    endfunction

    function automatic link_item_t make_item(event_t ev, logic [MS_W-1:0] ms);
        link_item_t it;
        it.pad        = '0;
        it.elapsed_ms = ms;
        it.event_code = ev;
        return it;
    endfunction

    // Mostly events that move the sequencer along, with elapsed times scaled
    // to the current thresholds so that both sides of each compare are hit.
    function automatic link_item_t random_item(int scale);
        int     pick;
        event_t ev;
        int     ms;
        pick = $urandom_range(0, 19);
        if (pick <= 8)
            ev = EV_NONE;
        else if (pick <= 12)
            ev = EV_ACK;
        else if (pick <= 16)
            ev = EV_CONNECTED;
        else if (pick <= 18)
            ev = EV_DISCONNECTED;
        else
            ev = event_t'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       ms = 0;
            1:       ms = 16'hFFFF;
            2, 3:    ms = $urandom_range(0, 16'hFFFF);
            default: ms = $urandom_range(0, scale);
        endcase
        return make_item(ev, MS_W'(ms));
    endfunction

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || expected_sensors.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_random(int count, logic [CFG_W-1:0] dly, logic [CFG_W-1:0] ack,
                              bit long_hold);
        int scale;
        write_reg(REG_DELAY_LIMIT, dly);
        write_reg(REG_ACK_TIMEOUT, ack);
        scale = (dly > ack) ? int'(dly) : int'(ack);
        scale = (scale / 2 < 16) ? 16 : scale / 2 + 1;
        for (int i = 0; i < count; i++)
            pending_events.push_back(random_item(scale));
        if (long_hold)
            hold_requests++;
        wait_drained();
    endtask

    // Sender: holds an offered transfer until it is taken, otherwise offers
    // the next event or idles for a random burst.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !offer_taken)
            ;
        else if (!calm && gap_left > 0)
        begin
            gap_left--;
            s_tvalid <= 1'b0;
        end
        else if (pending_events.size() == 0)
            s_tvalid <= 1'b0;
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap_left = $urandom_range(1, 16) - 1;
            s_tvalid <= 1'b0;
        end
        else
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_events[0];
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Samples register writes and both streams at the rising edge.
    always @(posedge clk)
    begin
        link_item_t          it;
        logic [SENSOR_W-1:0] want;
        offer_taken = 1'b0;
        if (rst_n)
        begin
            if (wr_en)
            begin
                case (reg_index_t'(wr_index))
                    REG_DELAY_LIMIT: delay_limit = wr_data;
                    REG_ACK_TIMEOUT: ack_timeout = wr_data;
                    default:         ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_sensors.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", m_tdata[SENSOR_W-1:0]));
                else
                begin
                    want = expected_sensors.pop_front();
                    if (m_tdata[SENSOR_W-1:0] !== want)
                        report_mismatch($sformatf("new_sensor %0d, expected %0d",
                                                  m_tdata[SENSOR_W-1:0], want));
                end
            end
            if (s_tvalid && s_tready)
            begin
                offer_taken = 1'b1;
                it = link_item_t'(s_tdata);
                void'(pending_events.pop_front());
                expected_sensors.push_back(predict_new_sensor(it));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: ignored events in idle, saturation, both
        // threshold boundaries, disconnect from refresh.
        pending_events.push_back(make_item(EV_NONE, 16'hFFFF));
        pending_events.push_back(make_item(EV_ACK, 16'h0000));
        pending_events.push_back(make_item(EV_DISCONNECTED, 16'h0001));
        pending_events.push_back(make_item(EV_CONNECTED, 16'h0000));
        pending_events.push_back(make_item(EV_ACK, 16'hFFFF));
        pending_events.push_back(make_item(EV_NONE, 16'd499));
        pending_events.push_back(make_item(EV_CONNECTED, 16'd1));
        pending_events.push_back(make_item(EV_ACK, 16'd499));
        pending_events.push_back(make_item(EV_NONE, 16'd1));
        pending_events.push_back(make_item(EV_DISCONNECTED, 16'hAAAA));
        wait_drained();

        // Zero thresholds: reconnect continues the round-robin and the slot wraps.
        write_reg(REG_DELAY_LIMIT, 16'd0);
        write_reg(REG_ACK_TIMEOUT, 16'd0);
        pending_events.push_back(make_item(EV_CONNECTED, 16'h5555));
        for (int i = 0; i < 21; i++)
            pending_events.push_back(make_item(event_t'((i % 2) ? EV_NONE : EV_ACK),
                                               (i % 3 == 0) ? 16'hFFFF : 16'h0000));
        wait_drained();

        run_random(150, 16'hFFFF, 16'hFFFF, 1'b0);
        run_random(200, CFG_W'($urandom_range(1, 3000)), CFG_W'($urandom_range(1, 3000)),
                   1'b1);
        run_random(150, 16'd0, 16'hFFFF, 1'b0);
        run_random(200, CFG_W'($urandom_range(0, 16'hFFFF)),
                   CFG_W'($urandom_range(0, 2000)), 1'b0);
        calm = 1'b1;
        run_random(100, CFG_W'($urandom_range(0, 1500)), CFG_W'($urandom_range(0, 1500)),
                   1'b0);

        repeat (5) @(posedge clk);
        if (expected_sensors.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_sensors.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
